// File: rtl/touch_median_affine_calibrate_unit_assert.svh
// Assertion macros used by the checker file tmac_checker.sv.
`ifndef TOUCH_MEDIAN_AFFINE_CALIBRATE_UNIT_ASSERT_SVH
`define TOUCH_MEDIAN_AFFINE_CALIBRATE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TMAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmac assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TMAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmac assertion failed");

`endif

// File: rtl/tmac_pkg.sv
`default_nettype none
package tmac_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam int RAW_W      = 12;
  localparam int SX_W       = 9;
  localparam int SY_W       = 8;
  localparam int GAIN_W     = 18;
  localparam int OFF_W      = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  localparam int CAL_SHIFT = 16;
  localparam int RAW_SHIFT = 12;
  localparam int PROD_W    = GAIN_W + RAW_W + 1;
  localparam int SUM_W     = 32;
  localparam int Q_W       = SUM_W - CAL_SHIFT;
  localparam int LIN_X_W   = RAW_W + $clog2(SCREEN_WIDTH);
  localparam int LIN_Y_W   = RAW_W + $clog2(SCREEN_HEIGHT);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic                     RST_CAL_ENABLE    = 1'b1;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_X_FROM_X = 18'sd5734;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_X_FROM_Y = 18'sd0;
  localparam logic signed [OFF_W-1:0]  RST_OFFSET_X      = -24'sd1146880;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_Y_FROM_X = 18'sd0;
  localparam logic signed [GAIN_W-1:0] RST_GAIN_Y_FROM_Y = 18'sd3502;
  localparam logic signed [OFF_W-1:0]  RST_OFFSET_Y      = -24'sd700960;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAL_ENABLE    = 3'd0,
    REG_GAIN_X_FROM_X = 3'd1,
    REG_GAIN_X_FROM_Y = 3'd2,
    REG_OFFSET_X      = 3'd3,
    REG_GAIN_Y_FROM_X = 3'd4,
    REG_GAIN_Y_FROM_Y = 3'd5,
    REG_OFFSET_Y      = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic             pressed;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
  } item_t;

  typedef struct packed {
    logic                     cal_enable;
    logic signed [GAIN_W-1:0] gain_x_from_x;
    logic signed [GAIN_W-1:0] gain_x_from_y;
    logic signed [OFF_W-1:0]  offset_x;
    logic signed [GAIN_W-1:0] gain_y_from_x;
    logic signed [GAIN_W-1:0] gain_y_from_y;
    logic signed [OFF_W-1:0]  offset_y;
  } cal_cfg_t;

  function automatic logic [RAW_W-1:0] median3(input logic [RAW_W-1:0] a,
                                               input logic [RAW_W-1:0] b,
                                               input logic [RAW_W-1:0] c);
    logic [RAW_W-1:0] lo;
    logic [RAW_W-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo) begin
      median3 = lo;
    end else if (c >= hi) begin
      median3 = hi;
    end else begin
      median3 = c;
    end
  endfunction

endpackage
`default_nettype wire

// File: rtl/touch_median_affine_calibrate_unit.sv
// An item accepted into the front register goes through the queue, the product
// stage and the result register to the result ports. Throughput: one item per
// cycle while results are popped, set by the two-stage multiply/clamp pipeline.
// Reset (rst_n low at a clock edge) empties every stage and the queue and
// loads the calibration registers with their default values.
`default_nettype none
module touch_median_affine_calibrate_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [tmac_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [tmac_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                                 in_push,
  output logic                                      in_full,
  input  wire logic                                 in_pen_down_start,
  input  wire logic                                 in_pen_down_end,
  input  wire logic [tmac_pkg::RAW_W-1:0]           in_x_first,
  input  wire logic [tmac_pkg::RAW_W-1:0]           in_x_second,
  input  wire logic [tmac_pkg::RAW_W-1:0]           in_x_third,
  input  wire logic [tmac_pkg::RAW_W-1:0]           in_y_first,
  input  wire logic [tmac_pkg::RAW_W-1:0]           in_y_second,
  input  wire logic [tmac_pkg::RAW_W-1:0]           in_y_third,
  output logic                                      out_empty,
  input  wire logic                                 out_pop,
  output logic                                      out_pressed,
  output logic [tmac_pkg::SX_W-1:0]                 out_screen_x,
  output logic [tmac_pkg::SY_W-1:0]                 out_screen_y,
  output logic [tmac_pkg::RAW_W-1:0]                out_raw_x_median,
  output logic [tmac_pkg::RAW_W-1:0]                out_raw_y_median
);

  tmac_pkg::cal_cfg_t cfg_r;
  tmac_pkg::cal_cfg_t cfg_nxt;
  tmac_pkg::item_t    front_item;
  tmac_pkg::item_t    q_item;
  logic               front_push;
  logic               q_full;
  logic               q_empty;
  logic               q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (tmac_pkg::reg_index_t'(cfg_index))
        tmac_pkg::REG_CAL_ENABLE:    cfg_nxt.cal_enable    = cfg_data[0];
        tmac_pkg::REG_GAIN_X_FROM_X: cfg_nxt.gain_x_from_x = cfg_data[tmac_pkg::GAIN_W-1:0];
        tmac_pkg::REG_GAIN_X_FROM_Y: cfg_nxt.gain_x_from_y = cfg_data[tmac_pkg::GAIN_W-1:0];
        tmac_pkg::REG_OFFSET_X:      cfg_nxt.offset_x      = cfg_data[tmac_pkg::OFF_W-1:0];
        tmac_pkg::REG_GAIN_Y_FROM_X: cfg_nxt.gain_y_from_x = cfg_data[tmac_pkg::GAIN_W-1:0];
        tmac_pkg::REG_GAIN_Y_FROM_Y: cfg_nxt.gain_y_from_y = cfg_data[tmac_pkg::GAIN_W-1:0];
        tmac_pkg::REG_OFFSET_Y:      cfg_nxt.offset_y      = cfg_data[tmac_pkg::OFF_W-1:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cal_enable    <= tmac_pkg::RST_CAL_ENABLE;
      cfg_r.gain_x_from_x <= tmac_pkg::RST_GAIN_X_FROM_X;
      cfg_r.gain_x_from_y <= tmac_pkg::RST_GAIN_X_FROM_Y;
      cfg_r.offset_x      <= tmac_pkg::RST_OFFSET_X;
      cfg_r.gain_y_from_x <= tmac_pkg::RST_GAIN_Y_FROM_X;
      cfg_r.gain_y_from_y <= tmac_pkg::RST_GAIN_Y_FROM_Y;
      cfg_r.offset_y      <= tmac_pkg::RST_OFFSET_Y;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tmac_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pen_down_start (in_pen_down_start),
    .in_pen_down_end   (in_pen_down_end),
    .in_x_first        (in_x_first),
    .in_x_second       (in_x_second),
    .in_x_third        (in_x_third),
    .in_y_first        (in_y_first),
    .in_y_second       (in_y_second),
    .in_y_third        (in_y_third),
    .q_push            (front_push),
    .q_full            (q_full),
    .q_item            (front_item)
  );

  tmac_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  tmac_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_empty          (q_empty),
    .q_pop            (q_pop),
    .q_item           (q_item),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_pressed      (out_pressed),
    .out_screen_x     (out_screen_x),
    .out_screen_y     (out_screen_y),
    .out_raw_x_median (out_raw_x_median),
    .out_raw_y_median (out_raw_y_median)
  );

endmodule
`default_nettype wire

// File: rtl/tmac_front.sv
`default_nettype none
module tmac_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic                          in_pen_down_start,
  input  wire logic                          in_pen_down_end,
  input  wire logic [tmac_pkg::RAW_W-1:0]    in_x_first,
  input  wire logic [tmac_pkg::RAW_W-1:0]    in_x_second,
  input  wire logic [tmac_pkg::RAW_W-1:0]    in_x_third,
  input  wire logic [tmac_pkg::RAW_W-1:0]    in_y_first,
  input  wire logic [tmac_pkg::RAW_W-1:0]    in_y_second,
  input  wire logic [tmac_pkg::RAW_W-1:0]    in_y_third,
  output logic                               q_push,
  input  wire logic                          q_full,
  output tmac_pkg::item_t                    q_item
);

  logic            valid_r;
  logic            valid_nxt;
  tmac_pkg::item_t item_r;
  tmac_pkg::item_t item_nxt;
  logic            accept;

  assign q_push  = valid_r && !q_full;
  assign in_full = valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_item  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (q_push) begin
      valid_nxt = 1'b0;
    end
  end

  // A lifted pen yields an all-zero item.
  always_comb begin
    item_nxt.pressed = in_pen_down_start && in_pen_down_end;
    if (item_nxt.pressed) begin
      item_nxt.raw_x = tmac_pkg::median3(in_x_first, in_x_second, in_x_third);
      item_nxt.raw_y = tmac_pkg::median3(in_y_first, in_y_second, in_y_third);
    end else begin
      item_nxt.raw_x = '0;
      item_nxt.raw_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tmac_fifo.sv
`default_nettype none
module tmac_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tmac_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output tmac_pkg::item_t     pop_item
);

  tmac_pkg::item_t                 mem_r [tmac_pkg::QDEPTH];
  logic [tmac_pkg::QPTR_W-1:0]     wr_ptr_r;
  logic [tmac_pkg::QPTR_W-1:0]     wr_ptr_nxt;
  logic [tmac_pkg::QPTR_W-1:0]     rd_ptr_r;
  logic [tmac_pkg::QPTR_W-1:0]     rd_ptr_nxt;
  logic [tmac_pkg::QCNT_W-1:0]     count_r;
  logic [tmac_pkg::QCNT_W-1:0]     count_nxt;
  logic                            do_push;
  logic                            do_pop;

  assign full     = (count_r == tmac_pkg::QCNT_W'(tmac_pkg::QDEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == tmac_pkg::QPTR_W'(tmac_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == tmac_pkg::QPTR_W'(tmac_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// File: rtl/tmac_back.sv
`default_nettype none
module tmac_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire tmac_pkg::cal_cfg_t         cfg,
  input  wire logic                       q_empty,
  output logic                            q_pop,
  input  wire tmac_pkg::item_t            q_item,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic                            out_pressed,
  output logic [tmac_pkg::SX_W-1:0]       out_screen_x,
  output logic [tmac_pkg::SY_W-1:0]       out_screen_y,
  output logic [tmac_pkg::RAW_W-1:0]      out_raw_x_median,
  output logic [tmac_pkg::RAW_W-1:0]      out_raw_y_median
);

  function automatic logic [tmac_pkg::Q_W-1:0] clamp_axis(
    input logic signed [tmac_pkg::SUM_W-1:0] sum,
    input logic [tmac_pkg::Q_W-1:0]          size
  );
    logic [tmac_pkg::Q_W-1:0] q;
    q = sum[tmac_pkg::SUM_W-1:tmac_pkg::CAL_SHIFT];
    if (sum[tmac_pkg::SUM_W-1]) begin
      clamp_axis = '0;
    end else if (q >= size) begin
      clamp_axis = size - 1'b1;
    end else begin
      clamp_axis = q;
    end
  endfunction

  logic                                   s1_v_r;
  logic                                   s1_pressed_r;
  logic                                   s1_cal_r;
  logic [tmac_pkg::RAW_W-1:0]             s1_rx_r;
  logic [tmac_pkg::RAW_W-1:0]             s1_ry_r;
  logic signed [tmac_pkg::PROD_W-1:0]     s1_pxx_r;
  logic signed [tmac_pkg::PROD_W-1:0]     s1_pxy_r;
  logic signed [tmac_pkg::PROD_W-1:0]     s1_pyx_r;
  logic signed [tmac_pkg::PROD_W-1:0]     s1_pyy_r;
  logic [tmac_pkg::LIN_X_W-1:0]           s1_linx_r;
  logic [tmac_pkg::LIN_Y_W-1:0]           s1_liny_r;

  logic                                   out_v_r;
  logic                                   pressed_r;
  logic [tmac_pkg::SX_W-1:0]              sx_r;
  logic [tmac_pkg::SY_W-1:0]              sy_r;
  logic [tmac_pkg::RAW_W-1:0]             rx_r;
  logic [tmac_pkg::RAW_W-1:0]             ry_r;

  logic                                   s2_ready;
  logic                                   s1_ready;
  logic signed [tmac_pkg::RAW_W:0]        rx_s;
  logic signed [tmac_pkg::RAW_W:0]        ry_s;
  logic signed [tmac_pkg::SUM_W-1:0]      sum_x;
  logic signed [tmac_pkg::SUM_W-1:0]      sum_y;
  logic [tmac_pkg::SX_W-1:0]              sx_nxt;
  logic [tmac_pkg::SY_W-1:0]              sy_nxt;

  assign s2_ready = !out_v_r || out_pop;
  assign s1_ready = !s1_v_r || s2_ready;
  assign q_pop    = !q_empty && s1_ready;

  assign rx_s = $signed({1'b0, q_item.raw_x});
  assign ry_s = $signed({1'b0, q_item.raw_y});

  assign sum_x = tmac_pkg::SUM_W'(s1_pxx_r) + tmac_pkg::SUM_W'(s1_pxy_r) +
                 tmac_pkg::SUM_W'(cfg.offset_x);
  assign sum_y = tmac_pkg::SUM_W'(s1_pyx_r) + tmac_pkg::SUM_W'(s1_pyy_r) +
                 tmac_pkg::SUM_W'(cfg.offset_y);

  always_comb begin
    if (!s1_pressed_r) begin
      sx_nxt = '0;
      sy_nxt = '0;
    end else if (s1_cal_r) begin
      sx_nxt = tmac_pkg::SX_W'(clamp_axis(sum_x,
                                          tmac_pkg::Q_W'(tmac_pkg::SCREEN_WIDTH)));
      sy_nxt = tmac_pkg::SY_W'(clamp_axis(sum_y,
                                          tmac_pkg::Q_W'(tmac_pkg::SCREEN_HEIGHT)));
    end else begin
      sx_nxt = tmac_pkg::SX_W'(s1_linx_r >> tmac_pkg::RAW_SHIFT);
      sy_nxt = tmac_pkg::SY_W'(s1_liny_r >> tmac_pkg::RAW_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= !q_empty;
      end
      if (s2_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_pressed_r <= q_item.pressed;
      s1_cal_r     <= cfg.cal_enable;
      s1_rx_r      <= q_item.raw_x;
      s1_ry_r      <= q_item.raw_y;
      s1_pxx_r     <= cfg.gain_x_from_x * rx_s;
      s1_pxy_r     <= cfg.gain_x_from_y * ry_s;
      s1_pyx_r     <= cfg.gain_y_from_x * rx_s;
      s1_pyy_r     <= cfg.gain_y_from_y * ry_s;
      s1_linx_r    <= tmac_pkg::LIN_X_W'(q_item.raw_x) *
                      tmac_pkg::LIN_X_W'(tmac_pkg::SCREEN_WIDTH);
      s1_liny_r    <= tmac_pkg::LIN_Y_W'(q_item.raw_y) *
                      tmac_pkg::LIN_Y_W'(tmac_pkg::SCREEN_HEIGHT);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_v_r) begin
      pressed_r <= s1_pressed_r;
      sx_r      <= sx_nxt;
      sy_r      <= sy_nxt;
      rx_r      <= s1_rx_r;
      ry_r      <= s1_ry_r;
    end
  end

  assign out_empty        = !out_v_r;
  assign out_pressed      = pressed_r;
  assign out_screen_x     = sx_r;
  assign out_screen_y     = sy_r;
  assign out_raw_x_median = rx_r;
  assign out_raw_y_median = ry_r;

endmodule
`default_nettype wire

// File: rtl/tmac_checker.sv
`default_nettype none
`include "touch_median_affine_calibrate_unit_assert.svh"
module tmac_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_empty,
  input wire logic                           out_pop,
  input wire logic                           out_pressed,
  input wire logic [tmac_pkg::SX_W-1:0]      out_screen_x,
  input wire logic [tmac_pkg::SY_W-1:0]      out_screen_y,
  input wire logic [tmac_pkg::RAW_W-1:0]     out_raw_x_median,
  input wire logic [tmac_pkg::RAW_W-1:0]     out_raw_y_median
);

  // A lifted pen must come out as an all-zero item.
  `TMAC_ASSERT_IMPL(a_lifted_zero, clk, rst_n, !out_empty && !out_pressed, (out_screen_x == '0) && (out_screen_y == '0) && (out_raw_x_median == '0) && (out_raw_y_median == '0))

  `TMAC_ASSERT_IMPL(a_x_on_screen, clk, rst_n, !out_empty, out_screen_x < tmac_pkg::SX_W'(tmac_pkg::SCREEN_WIDTH))

  `TMAC_ASSERT_IMPL(a_y_on_screen, clk, rst_n, !out_empty, out_screen_y < tmac_pkg::SY_W'(tmac_pkg::SCREEN_HEIGHT))

  `TMAC_ASSERT_NEXT(a_stall_holds, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_pressed) && $stable(out_screen_x) && $stable(out_screen_y) && $stable(out_raw_x_median) && $stable(out_raw_y_median))

endmodule

bind touch_median_affine_calibrate_unit tmac_checker u_tmac_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_pressed      (out_pressed),
  .out_screen_x     (out_screen_x),
  .out_screen_y     (out_screen_y),
  .out_raw_x_median (out_raw_x_median),
  .out_raw_y_median (out_raw_y_median)
);
`default_nettype wire
